FILE: hw/rtl/rsct_pkg.sv
`default_nettype none
package rsct_pkg;

  localparam int WORD_W        = 32;
  localparam int CNT_W         = 11;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [CNT_W-1:0] INIT_CAP_RESET = CNT_W'(10);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         item_count;
    logic [CNT_W-1:0]         current_capacity;
    logic [CNT_W-1:0]         largest_capacity;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rsct_in_if.sv
`default_nettype none
interface rsct_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [rsct_pkg::WORD_W-1:0]  push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink (input valid, input mode, input push_value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rsct_out_if.sv
`default_nettype none
interface rsct_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rsct_pkg::WORD_W-1:0]   pop_value;
  logic [rsct_pkg::STATUS_W-1:0]        status;
  logic [rsct_pkg::CNT_W-1:0]           item_count;
  logic [rsct_pkg::CNT_W-1:0]           current_capacity;
  logic [rsct_pkg::CNT_W-1:0]           largest_capacity;

  modport source (output valid, output pop_value, output status, output item_count,
                  output current_capacity, output largest_capacity, input ready);
  modport sink (input valid, input pop_value, input status, input item_count,
                input current_capacity, input largest_capacity, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rsct_ram.sv
`default_nettype none
module rsct_ram #(
  parameter int WIDTH = rsct_pkg::WORD_W,
  parameter int DEPTH = rsct_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rsct_out_buf.sv
`default_nettype none
module rsct_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire rsct_pkg::result_t wr_data,
  output logic                   room,
  rsct_out_if.source             rsp
);

  rsct_pkg::result_t entry [2];
  logic              wp;
  logic              rp;
  logic [1:0]        cnt;
  logic              rd;

  assign rd   = rsp.valid && rsp.ready;
  assign room = (cnt != 2'd2);

  assign rsp.valid            = (cnt != 2'd0);
  assign rsp.pop_value        = entry[rp].pop_value;
  assign rsp.status           = entry[rp].status;
  assign rsp.item_count       = entry[rp].item_count;
  assign rsp.current_capacity = entry[rp].current_capacity;
  assign rsp.largest_capacity = entry[rp].largest_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        entry[wp] <= wr_data;
        wp        <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    wr |-> cnt != 2'd2)
    else $error("result written into full buffer");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("buffer count out of range");

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> cnt == $past(cnt) - 2'd1)
    else $error("buffer count did not drop on read");

endmodule
`default_nettype wire

FILE: hw/rtl/rsct_ctrl.sv
`default_nettype none
module rsct_ctrl #(
  parameter int DEPTH = rsct_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [rsct_pkg::CNT_W-1:0]  cfg_data,
  rsct_in_if.sink                          cmd,
  input  wire logic                        room,
  output logic                             res_valid,
  output rsct_pkg::result_t                res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int OW = rsct_pkg::CNT_W;
  localparam int WW = rsct_pkg::WORD_W;

  typedef enum logic {S_IDLE, S_READ} state_t;

  function automatic logic [CW-1:0] eff_init(input logic [OW-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (32'(v) > 32'(DEPTH)) begin
      r = CW'(DEPTH);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  state_t        state, state_next;
  logic [OW-1:0] init_reg, init_reg_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cap, cap_next;
  logic [CW-1:0] peak, peak_next;

  logic [CW-1:0] init_eff;
  logic [CW:0]   dbl;
  logic [CW-1:0] cap_grow;
  logic [CW-1:0] cap_half;
  logic [CW-1:0] cap_push;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] cnt_dec;
  logic          full;
  logic          accept;

  logic          ram_we;
  logic          ram_re;
  logic [WW-1:0] ram_rdata;

  rsct_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (cmd.push_value),
    .re    (ram_re),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign cmd.ready = (state == S_IDLE) && room;
  assign accept    = cmd.valid && cmd.ready;
  assign init_eff  = eff_init(init_reg);
  assign full      = (count == CW'(DEPTH));
  assign cnt_inc   = count + CW'(1);
  assign cnt_dec   = count - CW'(1);
  assign dbl       = {cap, 1'b0};
  assign cap_grow  = (count >= cap) ?
                     ((dbl > (CW+1)'(DEPTH)) ? CW'(DEPTH) : dbl[CW-1:0]) : cap;
  assign cap_half  = ((cap_grow >> 1) < init_eff) ? init_eff : (cap_grow >> 1);
  assign cap_push  = ((cap_grow != init_eff) && (cnt_inc < (cap_grow >> 1))) ?
                     cap_half : cap_grow;

  always_comb begin
    state_next    = state;
    init_reg_next = init_reg;
    count_next    = count;
    cap_next      = cap;
    peak_next     = peak;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    res_valid     = 1'b0;
    res.pop_value = '0;
    res.status    = rsct_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (cfg_we) begin
          init_reg_next = cfg_data;
          count_next    = '0;
          cap_next      = eff_init(cfg_data);
          peak_next     = eff_init(cfg_data);
        end else if (accept) begin
          if (cmd.mode == rsct_pkg::MODE_PUSH) begin
            res_valid = 1'b1;
            if (full) begin
              res.status = rsct_pkg::ST_OVERFLOW;
            end else begin
              ram_we     = 1'b1;
              count_next = cnt_inc;
              cap_next   = cap_push;
              peak_next  = (cap_grow > peak) ? cap_grow : peak;
            end
          end else if (count == '0) begin
            res_valid     = 1'b1;
            res.pop_value = rsct_pkg::EMPTY_WORD;
            res.status    = rsct_pkg::ST_EMPTY;
          end else begin
            ram_re     = 1'b1;
            count_next = cnt_dec;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        res_valid     = 1'b1;
        res.pop_value = $signed(ram_rdata);
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    res.item_count       = OW'(count_next);
    res.current_capacity = OW'(cap_next);
    res.largest_capacity = OW'(peak_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      init_reg <= rsct_pkg::INIT_CAP_RESET;
      count    <= '0;
      cap      <= eff_init(rsct_pkg::INIT_CAP_RESET);
      peak     <= eff_init(rsct_pkg::INIT_CAP_RESET);
    end else begin
      state    <= state_next;
      init_reg <= init_reg_next;
      count    <= count_next;
      cap      <= cap_next;
      peak     <= peak_next;
    end
  end

  a_pop_result_next: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.mode == rsct_pkg::MODE_POP && count != '0) |=> res_valid)
    else $error("pop read did not produce an item");

  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> room)
    else $error("result produced with no buffer room");

  a_counter_bounds: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH) && cap <= CW'(DEPTH) && peak >= cap)
    else $error("counter out of range");

  a_cap_floor: assert property (@(posedge clk) disable iff (rst)
    cap >= init_eff)
    else $error("capacity below initial capacity");

endmodule
`default_nettype wire

FILE: hw/rtl/resizing_stack_capacity_tracker.sv
// LIFO stack of signed 32-bit words with logical capacity tracking.
// cmd channel (valid/ready): mode 0 pushes push_value, mode 1 pops.
// rsp channel (valid/ready): one item per command with pop_value, status
//   (ok, pop on empty, push overflow), item count, current and largest
//   capacity after the operation.
// cfg_we/cfg_data write initial_capacity (0 acts as 1, above DEPTH acts as
//   DEPTH); the write also empties the stack and reloads both capacities.
//   Write only while no command is in flight.
// Timing: a push, an empty pop or an overflow writes its result into the
//   result buffer at acceptance. A pop of a stored word first reads the word
//   RAM, whose read data is registered, and writes its result from the read
//   state; cmd is held off while the controller is in the read state.
// A two-entry result buffer sits in front of rsp, so a command is accepted
//   while one result still waits; with the buffer full, cmd.ready drops.
// Reset (rst, synchronous): stack empty, initial capacity 10, both
//   capacities 10, result buffer empty. RAM contents are not cleared.
`default_nettype none
module resizing_stack_capacity_tracker #(
  parameter int DEPTH = rsct_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [rsct_pkg::CNT_W-1:0]  cfg_data,
  rsct_in_if.sink                          cmd,
  rsct_out_if.source                       rsp
);

  logic              room;
  logic              res_valid;
  rsct_pkg::result_t res;

  rsct_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .room      (room),
    .res_valid (res_valid),
    .res       (res)
  );

  rsct_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_valid),
    .wr_data (res),
    .room    (room),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
module testbench;
  import rsct_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEFAULT;

  typedef struct {
    logic        op;
    logic [31:0] word;
    bit          typed;
    result_t     res;
  } op_row_t;

  typedef struct {
    logic [CNT_W-1:0] init_val;
    int               ops;
    int               push_pct;
  } phase_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  rsct_in_if  cmd ();
  rsct_out_if rsp ();

  resizing_stack_capacity_tracker u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stack shadow
  logic [31:0]      word_mem [STACK_DEPTH];
  int               depth_used;
  int               cap_now;
  int               cap_peak;
  logic [CNT_W-1:0] init_reg;

  result_t pending_results [$];
  int      mismatch_count = 0;
  int      rsp_seen = 0;
  int      sender_idle_pct = 0;
  int      recv_stall_pct = 0;

  function automatic int cap_floor(logic [CNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > STACK_DEPTH) return STACK_DEPTH;
    return int'(raw);
  endfunction

  function automatic void stack_restart(logic [CNT_W-1:0] raw);
    init_reg   = raw;
    depth_used = 0;
    cap_now    = cap_floor(raw);
    cap_peak   = cap_now;
  endfunction

  function automatic result_t stack_predict(logic op, logic [31:0] word);
    result_t r;
    int      floor_v;
    floor_v  = cap_floor(init_reg);
    r        = '0;
    r.status = ST_OK;
    if (op == MODE_PUSH) begin
      if (depth_used >= STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        if (depth_used >= cap_now) begin
          cap_now = (cap_now * 2 > STACK_DEPTH) ? STACK_DEPTH : cap_now * 2;
          if (cap_now > cap_peak) cap_peak = cap_now;
        end
        word_mem[depth_used] = word;
        depth_used++;
        if (cap_now != floor_v && depth_used < cap_now / 2)
          cap_now = (cap_now / 2 < floor_v) ? floor_v : cap_now / 2;
      end
    end else if (depth_used == 0) begin
      r.pop_value = EMPTY_WORD;
      r.status    = ST_EMPTY;
    end else begin
      depth_used--;
      r.pop_value = word_mem[depth_used];
    end
    r.item_count       = CNT_W'(depth_used);
    r.current_capacity = CNT_W'(cap_now);
    r.largest_capacity = CNT_W'(cap_peak);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH item %0d %s: got %0h want %0h at %0t",
             rsp_seen, field, got, want, $time);
    mismatch_count++;
  endtask

  // one item per handshake; valid stays high into the next call
  task automatic issue_op(logic op, logic [31:0] word, bit typed, result_t typed_res);
    result_t want;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    cmd.valid      = 1'b1;
    cmd.mode       = op;
    cmd.push_value = word;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    want = stack_predict(op, word);
    if (typed) want = typed_res;
    pending_results.push_back(want);
  endtask

  task automatic write_init(logic [CNT_W-1:0] value);
    @(negedge clk);
    cmd.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(posedge clk);
    stack_restart(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : rsp_check
    result_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", rsp.pop_value, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (rsp.pop_value !== want.pop_value)
          report_mismatch("pop_value", rsp.pop_value, want.pop_value);
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.item_count !== want.item_count)
          report_mismatch("item_count", 32'(rsp.item_count), 32'(want.item_count));
        if (rsp.current_capacity !== want.current_capacity)
          report_mismatch("current_capacity", 32'(rsp.current_capacity),
                          32'(want.current_capacity));
        if (rsp.largest_capacity !== want.largest_capacity)
          report_mismatch("largest_capacity", 32'(rsp.largest_capacity),
                          32'(want.largest_capacity));
      end
      rsp_seen++;
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    op_row_t     directed_ops [25];
    phase_t      phases [6];
    int          idle_send [4];
    int          idle_recv [4];
    int          n;
    int          sel;
    logic        op;
    logic [31:0] word;

    cmd.valid      = 1'b0;
    cmd.mode       = MODE_PUSH;
    cmd.push_value = '0;
    stack_restart(INIT_CAP_RESET);
    for (int k = 0; k < STACK_DEPTH; k++) word_mem[k] = '0;

    directed_ops = '{
      '{MODE_POP,  32'h0000_0000, 1'b1, '{EMPTY_WORD, ST_EMPTY, 11'd0, 11'd10, 11'd10}},
      '{MODE_PUSH, 32'h7FFF_FFFF, 1'b1, '{32'sd0, ST_OK, 11'd1, 11'd10, 11'd10}},
      '{MODE_PUSH, 32'h8000_0000, 1'b1, '{32'sd0, ST_OK, 11'd2, 11'd10, 11'd10}},
      '{MODE_PUSH, 32'h0000_0000, 1'b1, '{32'sd0, ST_OK, 11'd3, 11'd10, 11'd10}},
      '{MODE_PUSH, 32'hFFFF_FFFF, 1'b1, '{32'sd0, ST_OK, 11'd4, 11'd10, 11'd10}},
      '{MODE_POP,  32'h0000_0000, 1'b1, '{-32'sd1, ST_OK, 11'd3, 11'd10, 11'd10}},
      '{MODE_POP,  32'hFFFF_FFFF, 1'b1, '{32'sd0, ST_OK, 11'd2, 11'd10, 11'd10}},
      '{MODE_POP,  32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK, 11'd1, 11'd10, 11'd10}},
      '{MODE_POP,  32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK, 11'd0, 11'd10, 11'd10}},
      '{MODE_POP,  32'h1234_5678, 1'b1, '{EMPTY_WORD, ST_EMPTY, 11'd0, 11'd10, 11'd10}},
      '{MODE_PUSH, 32'h5555_5555, 1'b0, '0},
      '{MODE_PUSH, 32'hAAAA_AAAA, 1'b0, '0},
      '{MODE_PUSH, 32'h0000_0001, 1'b0, '0},
      '{MODE_PUSH, 32'h8000_0001, 1'b0, '0},
      '{MODE_PUSH, 32'h1234_5678, 1'b0, '0},
      '{MODE_PUSH, 32'hFEDC_BA98, 1'b0, '0},
      '{MODE_PUSH, 32'h0F0F_0F0F, 1'b0, '0},
      '{MODE_PUSH, 32'hF0F0_F0F0, 1'b0, '0},
      '{MODE_PUSH, 32'h7FFF_FFFE, 1'b0, '0},
      '{MODE_PUSH, 32'h0000_0100, 1'b0, '0},
      '{MODE_PUSH, 32'h3C3C_3C3C, 1'b0, '0},
      '{MODE_POP,  32'hFFFF_FFFF, 1'b0, '0},
      '{MODE_POP,  32'hFFFF_FFFF, 1'b0, '0},
      '{MODE_POP,  32'hFFFF_FFFF, 1'b0, '0},
      '{MODE_PUSH, 32'h0000_0042, 1'b0, '0}
    };

    // fill phase last: doubling from 3 saturates at the store size, then overflow
    phases = '{
      '{11'd1,    20,   55},
      '{11'd0,    20,   50},
      '{11'd2047, 20,   60},
      '{11'd1024, 20,   50},
      '{11'd5,    20,   60},
      '{11'd3,    1075, 99}
    };
    idle_send = '{0, 56, 0, 38};
    idle_recv = '{0, 0, 56, 38};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_ops[k])
      issue_op(directed_ops[k].op, directed_ops[k].word, directed_ops[k].typed,
               directed_ops[k].res);

    n = 0;
    foreach (phases[p]) begin
      write_init(phases[p].init_val);
      for (int i = 0; i < phases[p].ops; i++) begin
        sel             = (n / 40) % 4;
        sender_idle_pct = idle_send[sel];
        recv_stall_pct  = idle_recv[sel];
        op   = ($urandom_range(99) < phases[p].push_pct) ? MODE_PUSH : MODE_POP;
        word = $urandom();
        case ($urandom_range(15))
          0: word = 32'h7FFF_FFFF;
          1: word = 32'h8000_0000;
          2: word = 32'h0000_0000;
          3: word = 32'hFFFF_FFFF;
          default: ;
        endcase
        issue_op(op, word, 1'b0, '0);
        n++;
      end
    end

    @(negedge clk);
    cmd.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
